### rtl/evrp_pkg.sv
// ----------------------------------------------------------------------------
// evrp_pkg: shared definitions for the Euler vertex rotate / project core
// Field widths, angle fold points, register map and the sine table generator.
// ----------------------------------------------------------------------------
package evrp_pkg;

    // Field widths fixed by the interface
    localparam int VERTEX_W  = 8;
    localparam int ANGLE_W   = 9;
    localparam int ORIGIN_W  = 8;
    localparam int SCREEN_W  = 10;
    localparam int CFG_IDX_W = 1;

    // Default fraction bits of the sine / cosine values
    localparam int TRIG_FRAC_BITS_DEF = 14;

    // Configuration register map
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 1'd1;

    localparam logic [ORIGIN_W-1:0] ORIGIN_X_RST = 8'd64;
    localparam logic [ORIGIN_W-1:0] ORIGIN_Y_RST = 8'd32;

    // Angle fold points in whole degrees
    localparam logic [ANGLE_W-1:0] DEG_90  = 9'd90;
    localparam logic [ANGLE_W-1:0] DEG_180 = 9'd180;
    localparam logic [ANGLE_W-1:0] DEG_270 = 9'd270;
    localparam logic [ANGLE_W-1:0] DEG_360 = 9'd360;

    // One entry per degree of the first quadrant, 0..90
    localparam int TRIG_TAB_N = 91;
    localparam int TRIG_IDX_W = $clog2(TRIG_TAB_N);

    // Taylor series setup for the table
    localparam logic [63:0] PI_Q30       = 64'd3373259426;
    localparam int          SERIES_TERMS = 10;

    // Restoring shift-subtract quotient; elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // sin(k degrees) as unsigned Q2.30, series terms truncated; elaboration only
    function automatic logic [63:0] sin_q30(input int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] dvsr;
        x    = udiv64(64'(k) * PI_Q30 + 64'd90, 64'd180);
        x2   = (x * x) >> 30;
        term = x;
        acc  = x;
        for (int n = 1; n <= SERIES_TERMS; n++)
        begin
            dvsr = 64'((2 * n) * (2 * n + 1));
            term = udiv64((term * x2) >> 30, dvsr);
            if (n[0])
                acc = acc - term;
            else
                acc = acc + term;
        end
        return acc;
    endfunction

endpackage

### rtl/euler_vertex_rotate_project_core.sv
// ----------------------------------------------------------------------------
// euler_vertex_rotate_project_core: rotate a vertex by pitch, roll and yaw,
// then project orthographically onto the screen around a configured origin.
// Pipeline: 11 register stages; done is high in the same cycle as the result
//   registers that drive screen_x / screen_y.
// Throughput: one item per cycle; busy stays low, the multiplier chain is
//   fully pipelined and the receiver cannot stall, so nothing ever backs up.
// Reset: rst_n clears the valid chain and loads origin 64 / 32; payload
//   registers are not reset.
// ----------------------------------------------------------------------------
module euler_vertex_rotate_project_core
    import evrp_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // item in
    input  logic                        start,
    output logic                        busy,
    input  logic signed [VERTEX_W-1:0]  vertex_x,
    input  logic signed [VERTEX_W-1:0]  vertex_y,
    input  logic signed [VERTEX_W-1:0]  vertex_z,
    input  logic [ANGLE_W-1:0]          pitch_deg,
    input  logic [ANGLE_W-1:0]          roll_deg,
    input  logic [ANGLE_W-1:0]          yaw_deg,
    // item out
    output logic                        done,
    output logic signed [SCREEN_W-1:0]  screen_x,
    output logic signed [SCREEN_W-1:0]  screen_y,
    // configuration
    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [ORIGIN_W-1:0]         cfg_data
);

    localparam int F      = TRIG_FRAC_BITS;
    localparam int TW     = F + 2;              // sine / cosine
    localparam int VPW    = VERTEX_W + TW;      // vertex times trig
    localparam int W1     = VPW + 1;            // z1, x1 (scale S)
    localparam int ZSW    = W1 + TW;            // z1 * sr
    localparam int W2     = ZSW + 1;            // y2 (scale S^2)
    localparam int QW     = W2 - F;             // floor(y2 / S)
    localparam int XCW    = W1 + TW;            // x1 * cy
    localparam int QCW    = QW + TW;            // q * sy
    localparam int RW     = F + 1 + TW;         // rem * sy
    localparam int NRW    = RW + 1;
    localparam int GW     = QCW + 1;            // sums at scale S^2
    localparam int LAT    = 11;

    // ------------------------------------------------------------------
    // Configuration: origin registers, to be written only while the core is
    // idle; the user is bound by this, the block itself does not enforce it
    logic [ORIGIN_W-1:0] origin_x_reg;
    logic [ORIGIN_W-1:0] origin_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= ORIGIN_X_RST;
            origin_y_reg <= ORIGIN_Y_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_ORIGIN_X: origin_x_reg <= cfg_data;
                CFG_ORIGIN_Y: origin_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Valid chain: one bit per stage, the last one is the done strobe
    // ------------------------------------------------------------------
    logic           accept;
    logic [LAT-1:0] valid_reg;
    logic [LAT-1:0] valid_next;

    assign busy       = 1'b0;
    assign accept     = start && !busy;
    assign valid_next = {valid_reg[LAT-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign done = valid_reg[LAT-1];

    // ------------------------------------------------------------------
    // Stages 1-2: trig lookups; hold the vertex alongside
    // ------------------------------------------------------------------
    logic signed [TW-1:0] sp;
    logic signed [TW-1:0] cp;
    logic signed [TW-1:0] sr;
    logic signed [TW-1:0] cr;
    logic signed [TW-1:0] sy;
    logic signed [TW-1:0] cy;

    evrp_trig #(.FRAC_BITS(F)) u_trig_pitch
    (
        .clk     (clk),
        .angle   (pitch_deg),
        .sin_val (sp),
        .cos_val (cp)
    );

    evrp_trig #(.FRAC_BITS(F)) u_trig_roll
    (
        .clk     (clk),
        .angle   (roll_deg),
        .sin_val (sr),
        .cos_val (cr)
    );

    evrp_trig #(.FRAC_BITS(F)) u_trig_yaw
    (
        .clk     (clk),
        .angle   (yaw_deg),
        .sin_val (sy),
        .cos_val (cy)
    );

    logic signed [VERTEX_W-1:0] vx1_reg, vy1_reg, vz1_reg;
    logic signed [VERTEX_W-1:0] vx2_reg, vy2_reg, vz2_reg;

    always_ff @(posedge clk)
    begin
        vx1_reg <= vertex_x;
        vy1_reg <= vertex_y;
        vz1_reg <= vertex_z;
        vx2_reg <= vx1_reg;
        vy2_reg <= vy1_reg;
        vz2_reg <= vz1_reg;
    end

    // ------------------------------------------------------------------
    // Stage 3: pitch and roll partial products
    // ------------------------------------------------------------------
    logic signed [VPW-1:0] zcp_next, xsp_next, zsp_next, xcp_next, ycr_next;
    logic signed [VPW-1:0] zcp_reg, xsp_reg, zsp_reg, xcp_reg, ycr3_reg;
    logic signed [TW-1:0]  sr3_reg, sy3_reg, cy3_reg;

    assign zcp_next = vz2_reg * cp;
    assign xsp_next = vx2_reg * sp;
    assign zsp_next = vz2_reg * sp;
    assign xcp_next = vx2_reg * cp;
    assign ycr_next = vy2_reg * cr;

    always_ff @(posedge clk)
    begin
        zcp_reg  <= zcp_next;
        xsp_reg  <= xsp_next;
        zsp_reg  <= zsp_next;
        xcp_reg  <= xcp_next;
        ycr3_reg <= ycr_next;
        sr3_reg  <= sr;
        sy3_reg  <= sy;
        cy3_reg  <= cy;
    end

    // ------------------------------------------------------------------
    // Stage 4: finish the pitch rotation (z1, x1 at scale S)
    // ------------------------------------------------------------------
    logic signed [W1-1:0]  z1_next, x1_next;
    logic signed [W1-1:0]  z1_reg, x14_reg;
    logic signed [VPW-1:0] ycr4_reg;
    logic signed [TW-1:0]  sr4_reg, sy4_reg, cy4_reg;

    assign z1_next = W1'(zcp_reg) - W1'(xsp_reg);
    assign x1_next = W1'(zsp_reg) + W1'(xcp_reg);

    always_ff @(posedge clk)
    begin
        z1_reg   <= z1_next;
        x14_reg  <= x1_next;
        ycr4_reg <= ycr3_reg;
        sr4_reg  <= sr3_reg;
        sy4_reg  <= sy3_reg;
        cy4_reg  <= cy3_reg;
    end

    // ------------------------------------------------------------------
    // Stage 5: z1 * sr
    // ------------------------------------------------------------------
    logic signed [ZSW-1:0] zsr_next, zsr_reg;
    logic signed [VPW-1:0] ycr5_reg;
    logic signed [W1-1:0]  x15_reg;
    logic signed [TW-1:0]  sy5_reg, cy5_reg;

    assign zsr_next = z1_reg * sr4_reg;

    always_ff @(posedge clk)
    begin
        zsr_reg  <= zsr_next;
        ycr5_reg <= ycr4_reg;
        x15_reg  <= x14_reg;
        sy5_reg  <= sy4_reg;
        cy5_reg  <= cy4_reg;
    end

    // ------------------------------------------------------------------
    // Stage 6: finish the roll rotation (y2 at scale S^2)
    // ------------------------------------------------------------------
    logic signed [W2-1:0] ycr_ext, y2_next, y2_reg;
    logic signed [W1-1:0] x16_reg;
    logic signed [TW-1:0] sy6_reg, cy6_reg;

    assign ycr_ext = W2'(ycr5_reg);
    assign y2_next = (ycr_ext <<< F) - W2'(zsr_reg);

    always_ff @(posedge clk)
    begin
        y2_reg  <= y2_next;
        x16_reg <= x15_reg;
        sy6_reg <= sy5_reg;
        cy6_reg <= cy5_reg;
    end

    // ------------------------------------------------------------------
    // Stage 7: yaw products; split y2 into floor(y2 / S) and remainder
    // ------------------------------------------------------------------
    logic signed [W2-1:0]  y2_sh;
    logic signed [QW-1:0]  q_val;
    logic signed [F:0]     rem_val;
    logic signed [XCW-1:0] xcy_next, xsy_next, xcy_reg, xsy_reg;
    logic signed [QCW-1:0] qsy_next, qcy_next, qsy_reg, qcy_reg;
    logic signed [RW-1:0]  rsy_next, rcy_next, rsy_reg, rcy_reg;

    assign y2_sh   = y2_reg >>> F;
    assign q_val   = QW'(y2_sh);
    assign rem_val = {1'b0, y2_reg[F-1:0]};

    assign xcy_next = x16_reg * cy6_reg;
    assign xsy_next = x16_reg * sy6_reg;
    assign qsy_next = q_val * sy6_reg;
    assign qcy_next = q_val * cy6_reg;
    assign rsy_next = rem_val * sy6_reg;
    assign rcy_next = rem_val * cy6_reg;

    always_ff @(posedge clk)
    begin
        xcy_reg <= xcy_next;
        xsy_reg <= xsy_next;
        qsy_reg <= qsy_next;
        qcy_reg <= qcy_next;
        rsy_reg <= rsy_next;
        rcy_reg <= rcy_next;
    end

    // ------------------------------------------------------------------
    // Stage 8: integer parts of X, Y; X remainder term negated, Y as is
    // ------------------------------------------------------------------
    logic signed [GW-1:0]  px_next, py_next, px_reg, py_reg;
    logic signed [NRW-1:0] nrx_next, nry_next, nrx_reg, nry_reg;

    assign px_next  = GW'(xcy_reg) - GW'(qsy_reg);
    assign py_next  = GW'(xsy_reg) + GW'(qcy_reg);
    assign nrx_next = -NRW'(rsy_reg);
    assign nry_next = NRW'(rcy_reg);

    always_ff @(posedge clk)
    begin
        px_reg  <= px_next;
        py_reg  <= py_next;
        nrx_reg <= nrx_next;
        nry_reg <= nry_next;
    end

    // ------------------------------------------------------------------
    // Stage 9: fold in floor(remainder term / S), note a dropped fraction
    // ------------------------------------------------------------------
    logic signed [NRW-1:0] nrx_sh, nry_sh;
    logic signed [GW-1:0]  zx_next, zy_next, zx_reg, zy_reg;
    logic                  inx9_reg, iny9_reg;

    assign nrx_sh  = nrx_reg >>> F;
    assign nry_sh  = nry_reg >>> F;
    assign zx_next = px_reg + GW'(nrx_sh);
    assign zy_next = py_reg + GW'(nry_sh);

    always_ff @(posedge clk)
    begin
        zx_reg   <= zx_next;
        zy_reg   <= zy_next;
        inx9_reg <= |nrx_reg[F-1:0];
        iny9_reg <= |nry_reg[F-1:0];
    end

    // ------------------------------------------------------------------
    // Stage 10: add the screen origin at scale S^2
    // ------------------------------------------------------------------
    logic signed [GW-1:0] orgx_ext, orgy_ext;
    logic signed [GW-1:0] gx_next, gy_next, gx_reg, gy_reg;
    logic                 inx10_reg, iny10_reg;

    assign orgx_ext = GW'({1'b0, origin_x_reg});
    assign orgy_ext = GW'({1'b0, origin_y_reg});
    assign gx_next  = zx_reg + (orgx_ext <<< (2 * F));
    assign gy_next  = zy_reg + (orgy_ext <<< (2 * F));

    always_ff @(posedge clk)
    begin
        gx_reg    <= gx_next;
        gy_reg    <= gy_next;
        inx10_reg <= inx9_reg;
        iny10_reg <= iny9_reg;
    end

    // ------------------------------------------------------------------
    // Stage 11: floor by S^2, then bump negative inexact results toward
    // zero; keep the low screen bits
    // ------------------------------------------------------------------
    logic signed [GW-1:0]       flx, fly;
    logic                       corr_x, corr_y;
    logic signed [SCREEN_W-1:0] screen_x_next, screen_y_next;
    logic signed [SCREEN_W-1:0] screen_x_reg, screen_y_reg;

    assign flx    = gx_reg >>> (2 * F);
    assign fly    = gy_reg >>> (2 * F);
    assign corr_x = flx[GW-1] && (inx10_reg || (|gx_reg[2*F-1:0]));
    assign corr_y = fly[GW-1] && (iny10_reg || (|gy_reg[2*F-1:0]));

    assign screen_x_next = SCREEN_W'(flx) + SCREEN_W'({1'b0, corr_x});
    assign screen_y_next = SCREEN_W'(fly) + SCREEN_W'({1'b0, corr_y});

    always_ff @(posedge clk)
    begin
        screen_x_reg <= screen_x_next;
        screen_y_reg <= screen_y_next;
    end

    assign screen_x = screen_x_reg;
    assign screen_y = screen_y_reg;

endmodule

### rtl/evrp_trig.sv
// ----------------------------------------------------------------------------
// evrp_trig: two-stage sine / cosine lookup for one whole-degree angle
// Stage 1 wraps and folds the angle into the first quadrant, stage 2 reads
// the constant table and applies the sign.
// ----------------------------------------------------------------------------
module evrp_trig
    import evrp_pkg::*;
#(
    parameter int FRAC_BITS = TRIG_FRAC_BITS_DEF
)
(
    input  logic                      clk,
    input  logic [ANGLE_W-1:0]        angle,
    output logic signed [FRAC_BITS+1:0] sin_val,
    output logic signed [FRAC_BITS+1:0] cos_val
);

    localparam int TW = FRAC_BITS + 2;

    typedef struct packed {
        logic                  neg;
        logic [TRIG_IDX_W-1:0] idx;
    } fold_t;

    // Map 0..359 onto a first quadrant index and a sign
    function automatic fold_t fold(input logic [ANGLE_W-1:0] d);
        fold_t f;
        f.neg = 1'b0;
        if (d <= DEG_90)
            f.idx = TRIG_IDX_W'(d);
        else if (d <= DEG_180)
            f.idx = TRIG_IDX_W'(DEG_180 - d);
        else if (d <= DEG_270)
        begin
            f.idx = TRIG_IDX_W'(d - DEG_180);
            f.neg = 1'b1;
        end
        else
        begin
            f.idx = TRIG_IDX_W'(DEG_360 - d);
            f.neg = 1'b1;
        end
        return f;
    endfunction

    // Rounded magnitudes, built at elaboration
    logic [FRAC_BITS:0] mag_tab [0:TRIG_TAB_N-1];

    for (genvar k = 0; k < TRIG_TAB_N; k++)
    begin : g_tab
        localparam logic [63:0] Q30 = sin_q30(k);
        assign mag_tab[k] =
            (FRAC_BITS+1)'((Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
    end

    logic [ANGLE_W-1:0] ang_wrap;
    logic [ANGLE_W:0]   cos_sum;
    logic [ANGLE_W-1:0] cos_ang;

    assign ang_wrap = (angle >= DEG_360) ? angle - DEG_360 : angle;
    assign cos_sum  = {1'b0, ang_wrap} + {1'b0, DEG_90};
    assign cos_ang  = (cos_sum >= {1'b0, DEG_360}) ? ANGLE_W'(cos_sum - {1'b0, DEG_360})
                                                   : ANGLE_W'(cos_sum);

    fold_t sin_fold_reg;
    fold_t cos_fold_reg;

    always_ff @(posedge clk)
    begin
        sin_fold_reg <= fold(ang_wrap);
        cos_fold_reg <= fold(cos_ang);
    end

    logic signed [TW-1:0] sin_mag;
    logic signed [TW-1:0] cos_mag;
    logic signed [TW-1:0] sin_next;
    logic signed [TW-1:0] cos_next;
    logic signed [TW-1:0] sin_reg;
    logic signed [TW-1:0] cos_reg;

    assign sin_mag  = TW'(mag_tab[sin_fold_reg.idx]);
    assign cos_mag  = TW'(mag_tab[cos_fold_reg.idx]);
    assign sin_next = sin_fold_reg.neg ? -sin_mag : sin_mag;
    assign cos_next = cos_fold_reg.neg ? -cos_mag : cos_mag;

    always_ff @(posedge clk)
    begin
        sin_reg <= sin_next;
        cos_reg <= cos_next;
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule
